@@ rtl/pafa_pkg.sv @@
// Shared types, widths and saturation helpers for the polygon area frame average block.
// No dependencies; imported by the channel interfaces and by the top level.
package pafa_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned ACC_W           = 64;
  localparam int unsigned OUT_W           = 56;
  localparam int unsigned PC_W            = 16;
  localparam int unsigned FC_W            = 20;
  localparam int unsigned DIV_W           = 20;
  localparam int unsigned CNT_W           = $clog2(ACC_W);
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W      = 32;

  // Register index, taken from paddr bit 2
  localparam logic REG_POLYGON_COUNT = 1'b0;
  localparam logic REG_FRAME_COUNT   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_P1,
    ST_EDGE_P2,
    ST_EDGE_SUB,
    ST_EDGE_ACC,
    ST_CLS_P1,
    ST_CLS_P2,
    ST_CLS_SUB,
    ST_CLS_ACC,
    ST_FRM_ACC,
    ST_FDIV_LD,
    ST_DIV,
    ST_DIV_END,
    ST_RUN_ACC,
    ST_RDIV_LD,
    ST_OUT
  } pafa_state_t;

  // Signed add, clamp to the 64-bit limits on overflow
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

  // Clamp a 64-bit value to the signed 56-bit output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if ((&v[ACC_W-1:OUT_W-1]) || !(|v[ACC_W-1:OUT_W-1])) begin
      r = v[OUT_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ rtl/pafa_ifs.sv @@
// Valid/ready channel interfaces: vertex requests in, frame results out.
// Depends on pafa_pkg for the default coordinate width and the output width.
interface pafa_in_if import pafa_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic                          last_of_polygon;
  logic                          last_of_frame;

  modport source (output valid, x_coord, y_coord, last_of_polygon, last_of_frame,
                  input ready);
  modport sink   (input valid, x_coord, y_coord, last_of_polygon, last_of_frame,
                  output ready);
endinterface

interface pafa_out_if import pafa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] frame_area;
  logic signed [OUT_W-1:0] run_average;
  logic                    run_final;

  modport source (output valid, frame_area, run_average, run_final, input ready);
  modport sink   (input valid, frame_area, run_average, run_final, output ready);
endinterface

@@ rtl/polygon_area_frame_average.sv @@
// Top level: shoelace polygon area with frame and run averaging.
// Depends on pafa_pkg and the channel interfaces in pafa_ifs.sv.
//
// Usage
//   in_chan carries one vertex per request (signed Q15.8 x/y, last_of_polygon,
//   last_of_frame). out_chan carries one result per frame: the frame's mean
//   polygon area, the run average and run_final. An APB-style port sets
//   polygon_count (address 0) and frame_count (address 4); a zero acts as one.
//   Write the registers only while the block is idle.
// Sequencing
//   One signed multiplier, one saturating 64-bit adder and a radix-2 divider
//   are shared under a sequencer; ready is high only in the idle state.
//   The first vertex of a polygon is only stored. Any other vertex takes two
//   products, a subtract and an accumulate. A polygon's last vertex adds the
//   closing term and the frame accumulate, or just the latter for a lone vertex.
//   A frame's last vertex adds the frame divide (64 quotient bits, one per
//   cycle) and the run accumulate, plus the run divide when it completes the
//   run, plus the load of the result register.
// Reset
//   rst_n is synchronous, active low: clears all sums, the frame counter and
//   the result valid, and sets both divisors to one.
// Stall
//   The result waits in an output register; further vertices are accepted
//   until the next frame result is due, then the sequencer holds.
module polygon_area_frame_average import pafa_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pafa_in_if.sink               in_chan,
  pafa_out_if.source            out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned PROD_W = 2 * COORD_WIDTH;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);

  // ---------------------------------------------------------------- config
  logic [PC_W-1:0] pc_r;
  logic [FC_W-1:0] fc_r;
  logic            cfg_wr;
  logic [PC_W-1:0] pc_eff;
  logic [FC_W-1:0] fc_eff;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_W'(1);
      fc_r <= FC_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_POLYGON_COUNT: pc_r <= cfg_pwdata[PC_W-1:0];
        REG_FRAME_COUNT:   fc_r <= cfg_pwdata[FC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_POLYGON_COUNT: cfg_prdata = CFG_DATA_W'(pc_r);
      REG_FRAME_COUNT:   cfg_prdata = CFG_DATA_W'(fc_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // A zero divisor behaves as one
  assign pc_eff = (pc_r == '0) ? PC_W'(1) : pc_r;
  assign fc_eff = (fc_r == '0) ? FC_W'(1) : fc_r;

  // ---------------------------------------------------------------- state
  pafa_state_t state_r, state_nxt;
  logic        at_start_r, at_start_nxt;
  logic [FC_W-1:0] fd_r, fd_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic signed [COORD_WIDTH-1:0] first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [ACC_W-1:0]       poly_r, poly_nxt, frame_r, frame_nxt, run_r, run_nxt;

  logic signed [COORD_WIDTH-1:0] x_r, x_nxt, y_r, y_nxt;
  logic                          end_poly_r, end_poly_nxt, end_frame_r, end_frame_nxt;
  logic signed [ACC_W-1:0]       prod_r, prod_nxt, cross_r, cross_nxt;

  logic [ACC_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt, den_r, den_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt, run_div_r, run_div_nxt;

  logic signed [OUT_W-1:0] fa_r, fa_nxt, ra_r, ra_nxt;
  logic                    fin_r, fin_nxt;
  logic signed [OUT_W-1:0] out_fa_r, out_fa_nxt, out_ra_r, out_ra_nxt;
  logic                    out_fin_r, out_fin_nxt;

  // Shared arithmetic
  logic signed [COORD_WIDTH-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]      mul_p;
  logic signed [ACC_W-1:0]       add_a, add_b, add_s;
  logic [DIV_W:0]                div_shift;
  logic                          div_ge;
  logic signed [ACC_W-1:0]       quo_signed;
  logic [FC_W-1:0]               fd_inc;
  logic                          fin_now;
  logic                          in_accept;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_accept     = in_chan.valid && in_chan.ready;

  // Operand select for the multiplier
  always_comb begin
    unique case (state_r)
      ST_EDGE_P1: begin mul_a = prev_x_r;  mul_b = y_r;       end
      ST_EDGE_P2: begin mul_a = x_r;       mul_b = prev_y_r;  end
      ST_CLS_P1:  begin mul_a = x_r;       mul_b = first_y_r; end
      ST_CLS_P2:  begin mul_a = first_x_r; mul_b = y_r;       end
      default:    begin mul_a = x_r;       mul_b = y_r;       end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Operand select for the saturating adder
  always_comb begin
    unique case (state_r)
      ST_EDGE_SUB, ST_CLS_SUB: begin add_a = cross_r; add_b = -prod_r;          end
      ST_EDGE_ACC, ST_CLS_ACC: begin add_a = poly_r;  add_b = cross_r;          end
      ST_FRM_ACC:              begin add_a = frame_r; add_b = poly_r;           end
      ST_RUN_ACC:              begin add_a = run_r;   add_b = ACC_W'(fa_r);     end
      default:                 begin add_a = poly_r;  add_b = '0;               end
    endcase
  end
  assign add_s = sat_add(add_a, add_b);

  // Restoring divider step: one quotient bit a cycle
  assign div_shift  = {rem_r, quo_r[ACC_W-1]};
  assign div_ge     = (div_shift >= {1'b0, den_r});
  assign quo_signed = neg_r ? -quo_r : quo_r;

  assign fd_inc  = fd_r + FC_W'(1);
  assign fin_now = (fd_inc >= fc_eff) || (fd_inc == '0);

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    at_start_nxt  = at_start_r;
    fd_nxt        = fd_r;
    out_valid_nxt = out_valid_r;
    first_x_nxt   = first_x_r;
    first_y_nxt   = first_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    poly_nxt      = poly_r;
    frame_nxt     = frame_r;
    run_nxt       = run_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    end_poly_nxt  = end_poly_r;
    end_frame_nxt = end_frame_r;
    prod_nxt      = prod_r;
    cross_nxt     = cross_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    run_div_nxt   = run_div_r;
    fa_nxt        = fa_r;
    ra_nxt        = ra_r;
    fin_nxt       = fin_r;
    out_fa_nxt    = out_fa_r;
    out_ra_nxt    = out_ra_r;
    out_fin_nxt   = out_fin_r;

    // Drop the result once it has been taken
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          x_nxt         = in_chan.x_coord;
          y_nxt         = in_chan.y_coord;
          end_frame_nxt = in_chan.last_of_frame;
          end_poly_nxt  = in_chan.last_of_polygon || in_chan.last_of_frame;
          if (at_start_r) begin
            // Opening vertex: no edge yet; a lone vertex closes to zero area
            first_x_nxt = in_chan.x_coord;
            first_y_nxt = in_chan.y_coord;
            prev_x_nxt  = in_chan.x_coord;
            prev_y_nxt  = in_chan.y_coord;
            if (in_chan.last_of_polygon || in_chan.last_of_frame) begin
              state_nxt = ST_FRM_ACC;
            end else begin
              at_start_nxt = 1'b0;
            end
          end else begin
            state_nxt = ST_EDGE_P1;
          end
        end
      end
      ST_EDGE_P1: begin
        prod_nxt  = ACC_W'(mul_p);
        state_nxt = ST_EDGE_P2;
      end
      ST_EDGE_P2: begin
        cross_nxt = prod_r;
        prod_nxt  = ACC_W'(mul_p);
        state_nxt = ST_EDGE_SUB;
      end
      ST_EDGE_SUB: begin
        cross_nxt = add_s;
        state_nxt = ST_EDGE_ACC;
      end
      ST_EDGE_ACC: begin
        poly_nxt   = add_s;
        prev_x_nxt = x_r;
        prev_y_nxt = y_r;
        if (end_poly_r) begin
          state_nxt = ST_CLS_P1;
        end else begin
          at_start_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_CLS_P1: begin
        prod_nxt  = ACC_W'(mul_p);
        state_nxt = ST_CLS_P2;
      end
      ST_CLS_P2: begin
        cross_nxt = prod_r;
        prod_nxt  = ACC_W'(mul_p);
        state_nxt = ST_CLS_SUB;
      end
      ST_CLS_SUB: begin
        cross_nxt = add_s;
        state_nxt = ST_CLS_ACC;
      end
      ST_CLS_ACC: begin
        poly_nxt  = add_s;
        state_nxt = ST_FRM_ACC;
      end
      ST_FRM_ACC: begin
        frame_nxt    = add_s;
        poly_nxt     = '0;
        at_start_nxt = 1'b1;
        state_nxt    = end_frame_r ? ST_FDIV_LD : ST_IDLE;
      end
      ST_FDIV_LD: begin
        neg_nxt     = frame_r[ACC_W-1];
        quo_nxt     = frame_r[ACC_W-1] ? -frame_r : frame_r;
        den_nxt     = DIV_W'({pc_eff, 1'b0});
        rem_nxt     = '0;
        cnt_nxt     = '0;
        run_div_nxt = 1'b0;
        frame_nxt   = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = div_ge ? DIV_W'(div_shift - {1'b0, den_r}) : div_shift[DIV_W-1:0];
        quo_nxt = {quo_r[ACC_W-2:0], div_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        if (run_div_r) begin
          ra_nxt    = sat_out(quo_signed);
          state_nxt = ST_OUT;
        end else begin
          fa_nxt    = sat_out(quo_signed);
          state_nxt = ST_RUN_ACC;
        end
      end
      ST_RUN_ACC: begin
        run_nxt = add_s;
        fin_nxt = fin_now;
        if (fin_now) begin
          fd_nxt    = '0;
          state_nxt = ST_RDIV_LD;
        end else begin
          fd_nxt    = fd_inc;
          ra_nxt    = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_RDIV_LD: begin
        neg_nxt     = run_r[ACC_W-1];
        quo_nxt     = run_r[ACC_W-1] ? -run_r : run_r;
        den_nxt     = DIV_W'(fc_eff);
        rem_nxt     = '0;
        cnt_nxt     = '0;
        run_div_nxt = 1'b1;
        run_nxt     = '0;
        state_nxt   = ST_DIV;
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_fa_nxt    = fa_r;
          out_ra_nxt    = ra_r;
          out_fin_nxt   = fin_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      at_start_r  <= 1'b1;
      fd_r        <= '0;
      out_valid_r <= 1'b0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      poly_r      <= '0;
      frame_r     <= '0;
      run_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      at_start_r  <= at_start_nxt;
      fd_r        <= fd_nxt;
      out_valid_r <= out_valid_nxt;
      first_x_r   <= first_x_nxt;
      first_y_r   <= first_y_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      poly_r      <= poly_nxt;
      frame_r     <= frame_nxt;
      run_r       <= run_nxt;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    end_poly_r  <= end_poly_nxt;
    end_frame_r <= end_frame_nxt;
    prod_r      <= prod_nxt;
    cross_r     <= cross_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    cnt_r       <= cnt_nxt;
    neg_r       <= neg_nxt;
    run_div_r   <= run_div_nxt;
    fa_r        <= fa_nxt;
    ra_r        <= ra_nxt;
    fin_r       <= fin_nxt;
    out_fa_r    <= out_fa_nxt;
    out_ra_r    <= out_ra_nxt;
    out_fin_r   <= out_fin_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.frame_area  = out_fa_r;
  assign out_chan.run_average = out_ra_r;
  assign out_chan.run_final   = out_fin_r;

  // ---------------------------------------------------------------- checks
  // A vertex inside a polygon always starts the edge product sequence
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !at_start_r |=> state_r == ST_EDGE_P1)
    else $error("inner vertex did not start the edge sequence");

  // Folding a polygon into the frame clears the polygon sum and rearms the start
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FRM_ACC |=> at_start_r && poly_r == '0)
    else $error("polygon state not cleared after frame accumulate");

  // A run-final result leaves the frame counter and run sum cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_fin_r |-> fd_r == '0 && run_r == '0)
    else $error("run not restarted after final result");

endmodule

@@ tb/polygon_area_frame_average_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for polygon_area_frame_average: shoelace areas, frame and run means.
// Depends on pafa_pkg, the channel interfaces in pafa_ifs.sv and the top-level RTL.
module polygon_area_frame_average_test import pafa_pkg::*;;

  localparam int CW = COORD_WIDTH_DEF;
  // Cycles to let the sequencer finish after the last result, enough for a frame
  // end that also ends the run.
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  // Max-size squares per frame: large sums, large frame means
  localparam int BIG_SQUARES    = 6;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic signed [OUT_W-1:0] frame_area;
    logic signed [OUT_W-1:0] run_average;
    logic                    run_final;
  } frame_result_t;

  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

  // Tracks polygon, frame and run sums and holds the frame results still owed.
  class area_tracker;
    bit [PC_W-1:0] poly_count_reg;
    bit [FC_W-1:0] frame_count_reg;
    longint        first_x, first_y, prev_x, prev_y;
    bit            at_start;
    longint        poly_sum, frame_sum, run_sum;
    bit [FC_W-1:0] frames_done;
    frame_result_t pending_frames[$];
    int            errors, results, run_ends, vertices;

    function new();
      poly_count_reg  = 1;
      frame_count_reg = 1;
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      at_start  = 1'b1;
      poly_sum  = 0; frame_sum = 0; run_sum = 0;
      frames_done = 0;
      errors = 0; results = 0; run_ends = 0; vertices = 0;
    endfunction

    function void set_register(logic idx, int unsigned value);
      if (idx == REG_POLYGON_COUNT) poly_count_reg = value[PC_W-1:0];
      else                          frame_count_reg = value[FC_W-1:0];
    endfunction

    static function longint clamp_acc(longint a, longint b);
      longint s;
      s = a + b;
      if ((a < 0) == (b < 0) && (s < 0) != (a < 0)) begin
        s = (a < 0) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s;
    endfunction

    static function longint clamp_out(longint v);
      longint hi, lo;
      hi = (64'sd1 <<< (OUT_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void accept_vertex(coord_t xc, coord_t yc, bit lp, bit lf);
      longint        x, y, pc, fc, fa, ra;
      bit            fin;
      frame_result_t r;
      x = xc;
      y = yc;
      vertices++;
      if (at_start) begin
        first_x = x;
        first_y = y;
      end else begin
        poly_sum = clamp_acc(poly_sum, prev_x * y - x * prev_y);
      end
      prev_x = x;
      prev_y = y;
      // a frame end closes the polygon too
      if (lp || lf) begin
        poly_sum  = clamp_acc(poly_sum, x * first_y - first_x * y);
        frame_sum = clamp_acc(frame_sum, poly_sum);
        poly_sum  = 0;
        at_start  = 1'b1;
      end else begin
        at_start = 1'b0;
      end
      if (!lf) return;
      pc = (poly_count_reg == 0) ? 64'sd1 : longint'(poly_count_reg);
      fc = (frame_count_reg == 0) ? 64'sd1 : longint'(frame_count_reg);
      fa = clamp_out(frame_sum / (2 * pc));
      frame_sum = 0;
      run_sum = clamp_acc(run_sum, fa);
      frames_done = frames_done + 1'b1;
      fin = (longint'(frames_done) >= fc) || (frames_done == 0);
      ra = 0;
      if (fin) begin
        ra = clamp_out(run_sum / fc);
        run_sum = 0;
        frames_done = 0;
      end
      r.frame_area  = fa[OUT_W-1:0];
      r.run_average = ra[OUT_W-1:0];
      r.run_final   = fin;
      pending_frames.push_back(r);
    endfunction

    function void check_frame(logic signed [OUT_W-1:0] fa, logic signed [OUT_W-1:0] ra,
                              logic fin);
      frame_result_t want;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected frame result, got area %0d average %0d final %0b",
                 $time, fa, ra, fin);
        errors++;
        return;
      end
      want = pending_frames.pop_front();
      results++;
      if (fin === 1'b1) run_ends++;
      if (fa !== want.frame_area) begin
        $display("%0t: frame_area mismatch, expected %0d, got %0d", $time, want.frame_area, fa);
        errors++;
      end
      if (ra !== want.run_average) begin
        $display("%0t: run_average mismatch, expected %0d, got %0d", $time,
                 want.run_average, ra);
        errors++;
      end
      if (fin !== want.run_final) begin
        $display("%0t: run_final mismatch, expected %0b, got %0b", $time, want.run_final, fin);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  pafa_in_if #(.COORD_WIDTH(CW)) in_if ();
  pafa_out_if                    out_if ();

  area_tracker tracker = new();

  int burst_left   = 0;
  int settings_run = 1;
  int idle_cycles  = 0;
  int stall_pct    = 0;
  int stall_tick   = 0;

  polygon_area_frame_average #(.COORD_WIDTH(CW)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: switch the stall rate at random between none, 40% and 85%, so
  // that back-pressure lands on every phase of the sequencer.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) begin
      case ($urandom_range(0, 3))
        0, 1:    stall_pct <= 0;
        2:       stall_pct <= 40;
        default: stall_pct <= 85;
      endcase
    end
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Check every result request against the oldest frame still owed
  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) begin
      tracker.check_frame(out_if.frame_area, out_if.run_average, out_if.run_final);
    end
  end

  // Watchdog: count cycles in which no request moves on any port
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d frame results outstanding", $time,
               WATCHDOG_LIMIT, tracker.pending_frames.size());
      $display("polygon_area_frame_average_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mix of full-range, small and extreme coordinates
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      1: return coord_t'(int'($urandom_range(0, 4095)) - 2048);
      2: begin
        case ($urandom_range(0, 3))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Present one vertex request and hold it until accepted. Enter and leave at a
  // falling edge; between bursts drop valid for a random gap.
  task automatic send_vertex(coord_t x, coord_t y, bit lp, bit lf);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.x_coord         <= x;
    in_if.y_coord         <= y;
    in_if.last_of_polygon <= lp;
    in_if.last_of_frame   <= lf;
    in_if.valid           <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tracker.accept_vertex(x, y, lp, lf);
    @(negedge clk);
  endtask

  // Hold the sender until every owed result has arrived, then let the
  // sequencer run dry before anything else happens.
  task automatic drain_and_hold();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, access cycle, then release
  task automatic write_reg(logic idx, int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    tracker.set_register(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_counts(int unsigned polygons, int unsigned frames);
    write_reg(REG_POLYGON_COUNT, polygons);
    write_reg(REG_FRAME_COUNT, frames);
    settings_run++;
  endtask

  // Full-range square; counter-clockwise gives a positive area
  task automatic send_square(bit ccw, bit lp_end, bit lf_end);
    coord_t sq_x[4];
    coord_t sq_y[4];
    int     k;
    sq_x = '{C_MIN, C_MAX, C_MAX, C_MIN};
    sq_y = '{C_MIN, C_MIN, C_MAX, C_MAX};
    for (int i = 0; i < 4; i++) begin
      k = ccw ? i : 3 - i;
      send_vertex(sq_x[k], sq_y[k], (i == 3) ? lp_end : 1'b0, (i == 3) ? lf_end : 1'b0);
    end
  endtask

  // One frame of random polygons: the configured polygon count, or 1 to 4 when it
  // exceeds 6; some frames hold another count, end early or close a polygon early.
  task automatic send_frame();
    int  pc_eff, npoly, nv;
    bit  lp, lf;
    pc_eff = (tracker.poly_count_reg == 0) ? 1 : tracker.poly_count_reg;
    if (pc_eff > 6)                      npoly = $urandom_range(1, 4);
    else if ($urandom_range(0, 4) == 0)  npoly = $urandom_range(1, pc_eff + 2);
    else                                 npoly = pc_eff;
    for (int p = 0; p < npoly; p++) begin
      nv = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
      for (int v = 0; v < nv; v++) begin
        lp = (v == nv - 1);
        lf = lp && (p == npoly - 1);
        if (lf) begin
          lp = 1'($urandom_range(0, 1));
        end else if ($urandom_range(0, 29) == 0) begin
          lf = 1'b1;
        end else if (!lp && $urandom_range(0, 29) == 0) begin
          lp = 1'b1;
        end
        send_vertex(rand_coord(), rand_coord(), lp, lf);
      end
    end
  endtask

  // Random frames until n more vertices have gone in, with one full drain
  // part-way through.
  task automatic run_random(int n);
    int  target, halfway;
    bit  drained;
    target  = tracker.vertices + n;
    halfway = tracker.vertices + n / 2;
    drained = 1'b0;
    while (tracker.vertices < target) begin
      send_frame();
      if (!drained && tracker.vertices >= halfway) begin
        drain_and_hold();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.x_coord         = '0;
    in_if.y_coord         = '0;
    in_if.last_of_polygon = 1'b0;
    in_if.last_of_frame   = 1'b0;
    out_if.ready          = 1'b0;
    cfg_psel              = 1'b0;
    cfg_penable           = 1'b0;
    cfg_pwrite            = 1'b0;
    cfg_paddr             = '0;
    cfg_pwdata            = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset divisors of one: every frame completes a run.
    // One-vertex polygon at the extremes: zero area.
    send_vertex(C_MAX, C_MIN, 1'b1, 1'b1);
    // Small triangle with unit legs in Q15.8: half a square unit
    send_vertex(coord_t'(0), coord_t'(0), 1'b0, 1'b0);
    send_vertex(coord_t'(256), coord_t'(0), 1'b0, 1'b0);
    send_vertex(coord_t'(0), coord_t'(256), 1'b1, 1'b1);
    // Largest squares, both orientations; the second ends the frame without
    // marking the polygon end.
    send_square(1'b1, 1'b1, 1'b1);
    send_square(1'b0, 1'b0, 1'b1);
    // Lone vertex polygon inside a frame, then a two-vertex polygon
    send_vertex(coord_t'(-1), coord_t'(0), 1'b1, 1'b0);
    send_vertex(coord_t'(0), coord_t'(-1), 1'b0, 1'b0);
    send_vertex(C_MIN, C_MIN, 1'b1, 1'b1);
    drain_and_hold();

    // Zero divisors act as one; the second frame holds two polygons
    set_counts(0, 0);
    send_vertex(coord_t'(-256), coord_t'(-256), 1'b0, 1'b0);
    send_vertex(C_MAX, coord_t'(0), 1'b0, 1'b0);
    send_vertex(coord_t'(0), C_MAX, 1'b0, 1'b1);
    send_vertex(coord_t'(5), coord_t'(-7), 1'b0, 1'b0);
    send_vertex(coord_t'(-300), coord_t'(9), 1'b0, 1'b0);
    send_vertex(coord_t'(44), coord_t'(1000), 1'b1, 1'b0);
    send_vertex(C_MIN, C_MAX, 1'b0, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b0, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b1, 1'b1);
    run_random(30);
    drain_and_hold();

    set_counts(3, 2);
    run_random(90);
    drain_and_hold();

    // Largest counts: the run never completes here
    set_counts(16'hFFFF, 20'hFFFFF);
    run_random(50);
    drain_and_hold();

    // Frames of largest squares in both directions; the first frame also
    // closes out the run left open above.
    set_counts(1, 1);
    for (int i = 0; i < BIG_SQUARES; i++) send_square(1'b1, 1'b1, i == BIG_SQUARES - 1);
    for (int i = 0; i < BIG_SQUARES; i++) send_square(1'b0, 1'b1, i == BIG_SQUARES - 1);
    drain_and_hold();

    set_counts(2, 5);
    run_random(80);
    drain_and_hold();

    set_counts(1, 3);
    run_random(60);
    drain_and_hold();

    if (tracker.pending_frames.size() != 0) begin
      $display("%0t: %0d frame results never arrived", $time, tracker.pending_frames.size());
      tracker.errors++;
    end
    $display("Sent %0d vertices under %0d register settings.", tracker.vertices, settings_run);
    $display("Checked %0d frame results, %0d of them run ends; %0d errors.", tracker.results,
             tracker.run_ends, tracker.errors);
    if (tracker.errors == 0) begin
      $display("polygon_area_frame_average_test passed");
    end else begin
      $display("polygon_area_frame_average_test failed");
    end
    $finish;
  end

endmodule
